// ----- rtl/core/hsh_pkg.sv -----
// Shared types and constants for the RGB hue shifter.
// Used by the front stage, the divider pipeline, the back stage and the top level.
// No dependencies.
`timescale 1ns / 1ps

package hsh_pkg;

  // Channel and hue formats.
  localparam int CB     = 8;
  localparam int HB     = 16;
  // Hue quotient carries one extra bit for the round-up to a full turn.
  localparam int HQ_W   = HB + 1;
  // Hue dividend: numerator below 6*255 shifted by HQ_W, plus 6*delta.
  localparam int HN_W   = HQ_W + 12;
  // Hue divisor: 12*delta.
  localparam int HD_W   = 12;
  // Saturation dividend and divisor: 2*delta*255 + v and 2*v.
  localparam int SN_W   = 2 * CB + 2;
  localparam int SD_W   = CB + 1;
  // Hue sector numerator, below 6*255.
  localparam int NUM_W  = 11;

  // Register index of the hue offset.
  localparam logic REG_HUE_OFFSET = 1'b0;

  // Which channel holds the maximum.
  typedef enum logic [1:0] {
    MAX_R,
    MAX_G,
    MAX_B
  } max_sel_t;

  // Hue sector after rotation.
  typedef enum logic [2:0] {
    SEC_0,
    SEC_1,
    SEC_2,
    SEC_3,
    SEC_4,
    SEC_5
  } sector_t;

  // Dividend/divisor pairs entering the divider pipeline.
  typedef struct packed {
    logic [HN_W-1:0] hn;
    logic [HD_W-1:0] hd;
    logic [SN_W-1:0] sn;
    logic [SD_W-1:0] sd;
    logic [CB-1:0]   val;
  } div_in_t;

  // Quantized hue, saturation and value of the input pixel.
  typedef struct packed {
    logic [HB-1:0] hue;
    logic [CB-1:0] sat;
    logic [CB-1:0] val;
  } hsv_t;

  // One result item.
  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
    logic [HB-1:0] hue;
    logic [CB-1:0] sat;
    logic [CB-1:0] val;
  } pix_t;

endpackage

// ----- rtl/core/hsh_hsv_front.sv -----
// Front stage: max, min and delta of the pixel, and the dividends and divisors
// for the hue and saturation divisions. Depends on hsh_pkg.
`timescale 1ns / 1ps

module hsh_hsv_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  output logic                  out_valid,
  output hsh_pkg::div_in_t      div_in
);

  hsh_pkg::max_sel_t          maxsel;
  logic [7:0]                 vmax;
  logic [7:0]                 vmin;
  logic [7:0]                 delta;
  logic [hsh_pkg::NUM_W-1:0]  six_d;
  logic [hsh_pkg::NUM_W-1:0]  num;
  logic [15:0]                d255;
  logic                       valid_r;
  hsh_pkg::div_in_t           div_in_r;
  hsh_pkg::div_in_t           div_in_nxt;

  // Maximum with red, then green winning ties; minimum of all three.
  always_comb begin
    if (red >= green && red >= blue) begin
      maxsel = hsh_pkg::MAX_R;
      vmax   = red;
    end else if (green >= blue) begin
      maxsel = hsh_pkg::MAX_G;
      vmax   = green;
    end else begin
      maxsel = hsh_pkg::MAX_B;
      vmax   = blue;
    end
    vmin = (red < green) ? red : green;
    if (blue < vmin) begin
      vmin = blue;
    end
  end

  assign delta = vmax - vmin;
  assign six_d = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};

  // Hue numerator within the sector of the maximum channel.
  always_comb begin
    unique case (maxsel)
      hsh_pkg::MAX_R: begin
        if (green >= blue) begin
          num = {3'b000, green} - {3'b000, blue};
        end else begin
          num = {3'b000, green} + six_d - {3'b000, blue};
        end
      end
      hsh_pkg::MAX_G: num = {3'b000, blue} + {2'b00, delta, 1'b0} - {3'b000, red};
      default:        num = {3'b000, red} + {1'b0, delta, 2'b00} - {3'b000, green};
    endcase
  end

  assign d255 = {delta, 8'h00} - {8'h00, delta};

  // Round-half-up divisions are set up as floor((2n + d) / 2d).
  always_comb begin
    div_in_nxt.hn  = {1'b0, num, {hsh_pkg::HQ_W{1'b0}}}
                     + {{(hsh_pkg::HN_W - hsh_pkg::NUM_W){1'b0}}, six_d};
    div_in_nxt.hd  = (delta == 8'd0) ? hsh_pkg::HD_W'(12) : {six_d, 1'b0};
    div_in_nxt.sn  = {1'b0, d255, 1'b0} + {10'd0, vmax};
    div_in_nxt.sd  = (vmax == 8'd0) ? hsh_pkg::SD_W'(2) : {vmax, 1'b0};
    div_in_nxt.val = vmax;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_in_r <= div_in_nxt;
    end
  end

  assign out_valid = valid_r;
  assign div_in    = div_in_r;

endmodule

// ----- rtl/core/hsh_div_pipe.sv -----
// Pipelined restoring divider: one quotient bit per stage, hue and saturation
// lanes side by side with the value carried along. Depends on hsh_pkg.
`timescale 1ns / 1ps

module hsh_div_pipe (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  hsh_pkg::div_in_t  div_in,
  output logic              out_valid,
  output hsh_pkg::hsv_t     hsv
);

  localparam int NS  = hsh_pkg::HQ_W;
  localparam int HW  = hsh_pkg::HN_W + hsh_pkg::HQ_W;
  localparam int SW  = hsh_pkg::SN_W + hsh_pkg::HQ_W;

  logic                       vld_r  [NS];
  logic [hsh_pkg::HN_W-1:0]   hrem_r [NS];
  logic [hsh_pkg::HD_W-1:0]   hden_r [NS];
  logic [hsh_pkg::HQ_W-1:0]   hq_r   [NS];
  logic [hsh_pkg::SN_W-1:0]   srem_r [NS];
  logic [hsh_pkg::SD_W-1:0]   sden_r [NS];
  logic [hsh_pkg::HQ_W-1:0]   sq_r   [NS];
  logic [hsh_pkg::CB-1:0]     val_r  [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam int K = NS - 1 - i;

    logic                     vld_in;
    logic [hsh_pkg::HN_W-1:0] hrem_in;
    logic [hsh_pkg::HD_W-1:0] hden_in;
    logic [hsh_pkg::HQ_W-1:0] hq_in;
    logic [hsh_pkg::SN_W-1:0] srem_in;
    logic [hsh_pkg::SD_W-1:0] sden_in;
    logic [hsh_pkg::HQ_W-1:0] sq_in;
    logic [hsh_pkg::CB-1:0]   val_in;
    logic [HW-1:0]            hsh;
    logic [SW-1:0]            ssh;
    logic                     hge;
    logic                     sge;
    logic [hsh_pkg::HQ_W-1:0] hq_nxt;
    logic [hsh_pkg::HQ_W-1:0] sq_nxt;

    // First stage takes the dividends; later stages take the previous stage.
    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign hrem_in = div_in.hn;
      assign hden_in = div_in.hd;
      assign hq_in   = '0;
      assign srem_in = div_in.sn;
      assign sden_in = div_in.sd;
      assign sq_in   = '0;
      assign val_in  = div_in.val;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign hrem_in = hrem_r[i-1];
      assign hden_in = hden_r[i-1];
      assign hq_in   = hq_r[i-1];
      assign srem_in = srem_r[i-1];
      assign sden_in = sden_r[i-1];
      assign sq_in   = sq_r[i-1];
      assign val_in  = val_r[i-1];
    end

    // Compare the remainder with the divisor shifted to this quotient bit.
    assign hsh = {{(HW - hsh_pkg::HD_W){1'b0}}, hden_in} << K;
    assign ssh = {{(SW - hsh_pkg::SD_W){1'b0}}, sden_in} << K;
    assign hge = {{hsh_pkg::HQ_W{1'b0}}, hrem_in} >= hsh;
    assign sge = {{hsh_pkg::HQ_W{1'b0}}, srem_in} >= ssh;

    always_comb begin
      hq_nxt    = hq_in;
      hq_nxt[K] = hge;
      sq_nxt    = sq_in;
      sq_nxt[K] = sge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hrem_r[i] <= hge ? hrem_in - hsh[hsh_pkg::HN_W-1:0] : hrem_in;
        srem_r[i] <= sge ? srem_in - ssh[hsh_pkg::SN_W-1:0] : srem_in;
        hden_r[i] <= hden_in;
        sden_r[i] <= sden_in;
        hq_r[i]   <= hq_nxt;
        sq_r[i]   <= sq_nxt;
        val_r[i]  <= val_in;
      end
    end
  end

  // A hue that rounds up to a full turn wraps to zero.
  assign out_valid = vld_r[NS-1];
  assign hsv.hue   = hq_r[NS-1][hsh_pkg::HB-1:0];
  assign hsv.sat   = sq_r[NS-1][hsh_pkg::CB-1:0];
  assign hsv.val   = val_r[NS-1];

endmodule

// ----- rtl/core/hsh_hsv_back.sv -----
// Back stages: hue rotation, sector split and HSV-to-RGB conversion with
// rounding, ending in the output register. Depends on hsh_pkg.
`timescale 1ns / 1ps

module hsh_hsv_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  hsh_pkg::hsv_t         hsv,
  input  logic [15:0]           hue_offset,
  output logic                  out_valid,
  output hsh_pkg::pix_t         pix
);

  // Stage 1: rotated hue, sector, fraction and V*S.
  logic [15:0]       h2;
  logic [18:0]       scaled;
  logic              v1_r;
  hsh_pkg::hsv_t     hsv1_r;
  hsh_pkg::sector_t  sec1_r;
  logic [16:0]       t1_r;
  logic [16:0]       t1_nxt;
  logic [15:0]       vs1_r;

  assign h2     = hsv.hue + hue_offset;
  assign scaled = {3'b000, h2} * 19'd6;
  assign t1_nxt = scaled[16] ? (17'h10000 - {1'b0, scaled[15:0]})
                             : {1'b0, scaled[15:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      hsv1_r <= hsv;
      sec1_r <= hsh_pkg::sector_t'(scaled[18:16]);
      t1_r   <= t1_nxt;
      vs1_r  <= hsv.val * hsv.sat;
    end
  end

  // Stage 2: C*t term and the scaled minimum channel.
  logic              v2_r;
  hsh_pkg::hsv_t     hsv2_r;
  hsh_pkg::sector_t  sec2_r;
  logic [32:0]       p2_r;
  logic [15:0]       m2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hsv2_r <= hsv1_r;
      sec2_r <= sec1_r;
      p2_r   <= {17'd0, vs1_r} * {16'd0, t1_r};
      m2_r   <= {hsv1_r.val, 8'h00} - {8'h00, hsv1_r.val} - vs1_r;
    end
  end

  // Stage 3: halved rounding dividends, both to be divided by 255.
  logic              v3_r;
  hsh_pkg::hsv_t     hsv3_r;
  hsh_pkg::sector_t  sec3_r;
  logic [33:0]       xsum;
  logic [16:0]       wx3_r;
  logic [16:0]       wm3_r;

  assign xsum = {2'b00, m2_r, 16'h0000} + {1'b0, p2_r} + 34'h7F8000;

  always_ff @(posedge clk) begin
    if (en) begin
      hsv3_r <= hsv2_r;
      sec3_r <= sec2_r;
      wx3_r  <= xsum[32:16];
      wm3_r  <= {1'b0, m2_r} + 17'd127;
    end
  end

  // Stage 4: quotient estimate by 257/65536, low by at most one.
  logic              v4_r;
  hsh_pkg::hsv_t     hsv4_r;
  hsh_pkg::sector_t  sec4_r;
  logic [16:0]       wx4_r;
  logic [16:0]       wm4_r;
  logic [25:0]       px;
  logic [25:0]       pm;
  logic [8:0]        qx4_r;
  logic [8:0]        qm4_r;

  assign px = {9'd0, wx3_r} * 26'd257;
  assign pm = {9'd0, wm3_r} * 26'd257;

  always_ff @(posedge clk) begin
    if (en) begin
      hsv4_r <= hsv3_r;
      sec4_r <= sec3_r;
      wx4_r  <= wx3_r;
      wm4_r  <= wm3_r;
      qx4_r  <= px[24:16];
      qm4_r  <= pm[24:16];
    end
  end

  // Stage 5: correct the estimates, clamp and route channels by sector.
  logic [16:0]       rx;
  logic [16:0]       rm;
  logic [8:0]        qx;
  logic [8:0]        qm;
  logic [7:0]        xv;
  logic [7:0]        mv;
  logic [7:0]        cv;
  logic              v5_r;
  hsh_pkg::pix_t     pix_r;
  hsh_pkg::pix_t     pix_nxt;

  assign rx = wx4_r - ({qx4_r, 8'h00} - {8'h00, qx4_r});
  assign rm = wm4_r - ({qm4_r, 8'h00} - {8'h00, qm4_r});
  assign qx = (rx >= 17'd255) ? qx4_r + 9'd1 : qx4_r;
  assign qm = (rm >= 17'd255) ? qm4_r + 9'd1 : qm4_r;
  assign xv = qx[8] ? 8'hFF : qx[7:0];
  assign mv = qm[8] ? 8'hFF : qm[7:0];
  assign cv = hsv4_r.val;

  always_comb begin
    pix_nxt.hue = hsv4_r.hue;
    pix_nxt.sat = hsv4_r.sat;
    pix_nxt.val = hsv4_r.val;
    unique case (sec4_r)
      hsh_pkg::SEC_0: begin
        pix_nxt.red = cv; pix_nxt.green = xv; pix_nxt.blue = mv;
      end
      hsh_pkg::SEC_1: begin
        pix_nxt.red = xv; pix_nxt.green = cv; pix_nxt.blue = mv;
      end
      hsh_pkg::SEC_2: begin
        pix_nxt.red = mv; pix_nxt.green = cv; pix_nxt.blue = xv;
      end
      hsh_pkg::SEC_3: begin
        pix_nxt.red = mv; pix_nxt.green = xv; pix_nxt.blue = cv;
      end
      hsh_pkg::SEC_4: begin
        pix_nxt.red = xv; pix_nxt.green = mv; pix_nxt.blue = cv;
      end
      default: begin
        pix_nxt.red = cv; pix_nxt.green = mv; pix_nxt.blue = xv;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign out_valid = v5_r;
  assign pix       = pix_r;

endmodule

// ----- rtl/core/rgb_hue_shifter.sv -----
// RGB hue shifter: RGB to HSV, hue rotation, HSV back to RGB.
// Top level; instantiates hsh_hsv_front, hsh_div_pipe, hsh_hsv_back; uses hsh_pkg.
//
// Usage: pixels enter on the in_ stream, one item per pixel, and leave on the
// out_ stream carrying the rotated pixel with the input hue, saturation and
// value. The hue offset register at address 0 of the cfg_ port sets the
// rotation in units of 1/65536 turn; write it only while the block is idle.
// From acceptance to out_tvalid an item passes one front stage, 17
// divider stages (one quotient bit per stage for hue and saturation), and five
// back-conversion stages ending in the output register.
// Throughput is one item per cycle while the receiver takes results; every
// stage, the 17-stage divider among them, is fully pipelined.
// When the receiver stalls, the whole pipeline holds and in_tready falls until
// the waiting result is taken; nothing is lost or repeated.
// Reset clears all valid bits and the hue offset to 0.
`timescale 1ns / 1ps

module rgb_hue_shifter (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // out_red, out_green, out_blue, in_hue[16], in_sat, in_val
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic              en;
  logic              cfg_wr;
  logic [15:0]       hue_offset_r;
  logic [15:0]       hue_offset_nxt;
  logic              f_valid;
  hsh_pkg::div_in_t  f_div;
  logic              d_valid;
  hsh_pkg::hsv_t     d_hsv;
  hsh_pkg::pix_t     pix;

  // The pipeline advances unless a result waits on a stalled receiver.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[2] == hsh_pkg::REG_HUE_OFFSET);
  assign hue_offset_nxt = cfg_wr ? cfg_pwdata[15:0] : hue_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_offset_r <= 16'h0000;
    end else begin
      hue_offset_r <= hue_offset_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == hsh_pkg::REG_HUE_OFFSET) ? {16'h0000, hue_offset_r}
                                                                 : 32'h0000_0000;

  hsh_hsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .red       (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .blue      (in_tdata[23:16]),
    .out_valid (f_valid),
    .div_in    (f_div)
  );

  hsh_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .div_in    (f_div),
    .out_valid (d_valid),
    .hsv       (d_hsv)
  );

  hsh_hsv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (d_valid),
    .hsv        (d_hsv),
    .hue_offset (hue_offset_r),
    .out_valid  (out_tvalid),
    .pix        (pix)
  );

  assign out_tdata = {pix.val, pix.sat, pix.hue, pix.blue, pix.green, pix.red};

  // A gray result has every channel equal to the value.
  a_gray_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[47:40] == 8'd0) |->
      (out_tdata[7:0] == out_tdata[55:48] && out_tdata[15:8] == out_tdata[55:48]
       && out_tdata[23:16] == out_tdata[55:48]))
    else $error("gray item has channels unequal to value");

  // No rotated channel exceeds the value of the input pixel.
  a_chan_le_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] <= out_tdata[55:48] && out_tdata[15:8] <= out_tdata[55:48]
                    && out_tdata[23:16] <= out_tdata[55:48]))
    else $error("rotated channel above value");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A hue offset write reads back on the next cycle.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (hue_offset_r == $past(cfg_pwdata[15:0])))
    else $error("hue offset write lost");

endmodule

// ----- tb/sv/tb_rgb_hue_shifter.sv -----
// Self-checking testbench for the RGB hue shifter: drives pixels and hue offsets,
// predicts every result with an integer HSV model and compares the whole result word.
// Depends on hsh_pkg and rgb_hue_shifter.
`timescale 1ns / 1ps

module tb_rgb_hue_shifter;

  localparam int PIPE_LAT = 23;
  localparam int HOLD_CYCLES = 200;
  localparam logic [2:0] ADDR_HUE_OFFSET = 3'd0;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // red [7:0], green [15:8], blue [23:16]
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;   // red, green, blue, hue[16], sat, val
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rgb_hue_shifter DUT (.*);

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
  } shifted_pix_t;

  logic [23:0]  pixel_queue[$];
  shifted_pix_t expected_pix[$];
  logic [15:0]  hue_offset_model;
  bit           failed;
  bit           feed_enable;
  bit           hold_req;
  bit           hold_done;
  int           burst_left;
  int           gap_left;
  int           hold_left;
  int           stall_phase;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic longint unsigned div_round(longint unsigned n, longint unsigned d);
    return (2 * n + d) / (2 * d);
  endfunction

  function automatic longint unsigned sat_chan(longint unsigned x);
    return x > 255 ? 255 : x;
  endfunction

  // Integer RGB -> HSV -> rotate -> RGB.
  function automatic shifted_pix_t rotate_pixel(logic [23:0] px, logic [15:0] offs);
    longint unsigned r, g, b, v, mn, dl, s, h, num, h2, sc, t, den, vn, mnum, xn;
    longint unsigned cv, mv, xv;
    hsh_pkg::max_sel_t ms;
    hsh_pkg::sector_t sec;
    shifted_pix_t res;
    r = 64'(px[7:0]);
    g = 64'(px[15:8]);
    b = 64'(px[23:16]);
    if (r >= g && r >= b) begin
      v = r; ms = hsh_pkg::MAX_R;
    end else if (g >= b) begin
      v = g; ms = hsh_pkg::MAX_G;
    end else begin
      v = b; ms = hsh_pkg::MAX_B;
    end
    mn = r < g ? r : g;
    if (b < mn) mn = b;
    dl = v - mn;
    s = 0;
    h = 0;
    if (v != 0) s = sat_chan(div_round(dl * 255, v));
    if (dl != 0) begin
      case (ms)
        hsh_pkg::MAX_R: num = (g >= b) ? g - b : g + 6 * dl - b;
        hsh_pkg::MAX_G: num = b + 2 * dl - r;
        default: num = r + 4 * dl - g;
      endcase
      h = div_round(num * 65536, 6 * dl) & 16'hFFFF;
    end
    h2 = (h + offs) & 16'hFFFF;
    sc = h2 * 6;
    sec = hsh_pkg::sector_t'(sc >> 16);
    t = (sc[16]) ? 65536 - (sc & 16'hFFFF) : (sc & 16'hFFFF);
    den = 255 * 65536;
    vn = v * den;
    mnum = vn - v * s * 65536;
    xn = mnum + v * s * t;
    cv = sat_chan(div_round(vn, den));
    mv = sat_chan(div_round(mnum, den));
    xv = sat_chan(div_round(xn, den));
    case (sec)
      hsh_pkg::SEC_0: begin res.red = 8'(cv); res.green = 8'(xv); res.blue = 8'(mv); end
      hsh_pkg::SEC_1: begin res.red = 8'(xv); res.green = 8'(cv); res.blue = 8'(mv); end
      hsh_pkg::SEC_2: begin res.red = 8'(mv); res.green = 8'(cv); res.blue = 8'(xv); end
      hsh_pkg::SEC_3: begin res.red = 8'(mv); res.green = 8'(xv); res.blue = 8'(cv); end
      hsh_pkg::SEC_4: begin res.red = 8'(xv); res.green = 8'(mv); res.blue = 8'(cv); end
      default: begin res.red = 8'(cv); res.green = 8'(mv); res.blue = 8'(xv); end
    endcase
    res.hue = 16'(h);
    res.sat = 8'(s);
    res.val = 8'(v);
    return res;
  endfunction

  // Driver: bursts and gaps; a new item is loaded only after the last is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) expected_pix.push_back(rotate_pixel(in_tdata, hue_offset_model));
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (feed_enable && pixel_queue.size() > 0) begin
        in_tdata <= pixel_queue.pop_front();
        in_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern by phase, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_phase <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      stall_phase <= (stall_phase + 1) % 300;
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (stall_phase < 100) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    shifted_pix_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pix.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        failed <= 1'b1;
      end else begin
        e = expected_pix.pop_front();
        if ({e.val, e.sat, e.hue, e.blue, e.green, e.red} !== out_tdata) begin
          $display("%0t: mismatch expected r%0d g%0d b%0d h%0d s%0d v%0d", $time,
                   e.red, e.green, e.blue, e.hue, e.sat, e.val);
          $display("%0t:          actual r%0d g%0d b%0d h%0d s%0d v%0d", $time,
                   out_tdata[7:0], out_tdata[15:8], out_tdata[23:16],
                   out_tdata[39:24], out_tdata[47:40], out_tdata[55:48]);
          failed <= 1'b1;
        end
      end
    end
  end

  task automatic write_hue_offset(logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_HUE_OFFSET;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    hue_offset_model = value[15:0];
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Release the queued items, wait until all results are back, then settle.
  task automatic run_phase();
    feed_enable = 1'b1;
    while (pixel_queue.size() > 0 || in_tvalid || expected_pix.size() > 0) @(posedge clk);
    feed_enable = 1'b0;
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  function automatic logic [23:0] random_pixel();
    logic [7:0] a, b2, c;
    a = 8'($urandom_range(0, 255));
    b2 = 8'($urandom_range(0, 255));
    c = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: return {a, a, a};
      1: return {a, b2, b2};
      2: return {b2, a, b2};
      3: return {b2, b2, a};
      default: return {c, b2, a};
    endcase
  endfunction

  initial begin
    logic [15:0] offsets[6];
    offsets = '{16'd0, 16'hFFFF, 16'h8000, 16'h2AAB, 16'h0001, 16'h5555};
    rst_n = 1'b0;
    feed_enable = 1'b0;
    hold_req = 1'b0;
    hue_offset_model = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, gray, black, ties for the maximum and every sector.
    pixel_queue = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                    24'h00FFFF, 24'hFF00FF, 24'hFFFF00, 24'h808080, 24'h010000,
                    24'h000001, 24'hFF00FE, 24'h7F8001, 24'h0180FF, 24'hAA55AA,
                    24'h55AAAA, 24'h010101, 24'hFE01FF, 24'h123456, 24'hFFFE00};
    run_phase();

    // Random phases over several offsets, the extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      write_hue_offset(ph == 2 ? 32'hFFFF_0000 | offsets[ph] : {16'hFFFF, offsets[ph]});
      for (int i = 0; i < 180; i++) pixel_queue.push_back(random_pixel());
      if (ph == 3) begin
        // Long receiver hold-off while the sender keeps offering items.
        hold_req = 1'b1;
      end
      run_phase();
    end
    write_hue_offset($urandom);
    for (int i = 0; i < 200; i++) pixel_queue.push_back(random_pixel());
    run_phase();

    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/hsh_pkg.sv
rtl/core/hsh_hsv_front.sv
rtl/core/hsh_div_pipe.sv
rtl/core/hsh_hsv_back.sv
rtl/core/rgb_hue_shifter.sv
tb/sv/tb_rgb_hue_shifter.sv
